// ===== rtl/fqwr_pkg.sv =====
// Shared constants and codes for the FIFO queue with remove-by-value.
package fqwr_pkg;

  localparam int DATA_W    = 32;
  localparam int DEPTH_DEF = 16;

  localparam logic [1:0] REQ_ENQ  = 2'd0;
  localparam logic [1:0] REQ_DEQ  = 2'd1;
  localparam logic [1:0] REQ_REM  = 2'd2;
  localparam logic [1:0] REQ_SHOW = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_NOTFOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

endpackage

// ===== rtl/fqwr_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
module fqwr_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/fifo_queue_with_remove_by_value_core.sv =====
// Top level: order-keeping FIFO with remove-by-value, entries held in one RAM.
//
//   Channel   Handshake            Payload
//   request   start_i / busy_o     req_type_i, data_value_i
//   result    res_valid_o strobe   status_o, result_value_o, last_o
//
// Enqueue and the full and empty answers are registered and appear in the cycle
// after the accepting edge; dequeue reads the oldest entry, passes through S_DEQ
// and then gives its beat. Show and remove walk all N stored entries, found or not,
// since the single read port of the entry RAM visits one entry per cycle.
// Reset is asynchronous and empties the queue; the RAM contents are not cleared.
// Results are strobed for one cycle and cannot be held off by the receiver.
module fifo_queue_with_remove_by_value_core #(
  parameter int DEPTH = fqwr_pkg::DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic [1:0]                          req_type_i,
  input  logic signed [fqwr_pkg::DATA_W-1:0]  data_value_i,
  output logic                                res_valid_o,
  output logic [1:0]                          status_o,
  output logic signed [fqwr_pkg::DATA_W-1:0]  result_value_o,
  output logic                                last_o
);

  import fqwr_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_WALK
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       head_q, head_d;
  logic [CW-1:0]       count_q, count_d;
  logic [CW-1:0]       issue_q, issue_d;
  logic [CW-1:0]       rd_idx_q, rd_idx_d;
  logic                rd_vld_q, rd_vld_d;
  logic                found_q, found_d;
  logic                show_q, show_d;
  logic [DATA_W-1:0]   value_q, value_d;
  logic [DATA_W-1:0]   hit_q, hit_d;

  logic                res_valid_q, res_valid_d;
  logic [1:0]          status_q, status_d;
  logic [DATA_W-1:0]   res_val_q, res_val_d;
  logic                last_q, last_d;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [DATA_W-1:0]   wdata;
  logic                re;
  logic [AW-1:0]       raddr;
  logic [DATA_W-1:0]   rdata;
  logic                accept;

  // Maps a position counted from the oldest entry to a RAM address.
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] idx);
    logic [AW:0] s;
    s = {1'b0, head} + (AW+1)'(idx);
    if (s >= (AW+1)'(DEPTH)) begin
      s = s - (AW+1)'(DEPTH);
    end
    return s[AW-1:0];
  endfunction

  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    count_d     = count_q;
    issue_d     = issue_q;
    rd_idx_d    = rd_idx_q;
    rd_vld_d    = 1'b0;
    found_d     = found_q;
    show_d      = show_q;
    value_d     = value_q;
    hit_d       = hit_q;
    res_valid_d = 1'b0;
    status_d    = status_q;
    res_val_d   = res_val_q;
    last_d      = last_q;
    we          = 1'b0;
    waddr       = phys(head_q, count_q);
    wdata       = data_value_i;
    re          = 1'b0;
    raddr       = head_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_val_d = '0;
          last_d    = 1'b1;
          status_d  = ST_OK;
          if (req_type_i == REQ_ENQ) begin
            res_valid_d = 1'b1;
            if (count_q == CW'(DEPTH)) begin
              status_d = ST_FULL;
            end else begin
              we      = 1'b1;
              count_d = count_q + CW'(1);
            end
          end else if (count_q == '0) begin
            res_valid_d = 1'b1;
            status_d    = ST_EMPTY;
          end else begin
            // The oldest entry is read at the accepting edge.
            re       = 1'b1;
            rd_vld_d = 1'b1;
            rd_idx_d = '0;
            issue_d  = CW'(1);
            found_d  = 1'b0;
            show_d   = (req_type_i == REQ_SHOW);
            value_d  = data_value_i;
            state_d  = (req_type_i == REQ_DEQ) ? S_DEQ : S_WALK;
          end
        end
      end

      S_DEQ: begin
        res_valid_d = 1'b1;
        status_d    = ST_OK;
        res_val_d   = rdata;
        last_d      = 1'b1;
        head_d      = (head_q == AW'(DEPTH - 1)) ? '0 : head_q + AW'(1);
        count_d     = count_q - CW'(1);
        state_d     = S_IDLE;
      end

      S_WALK: begin
        // Reads run one entry ahead of the compare and the move-down writes.
        if (issue_q < count_q) begin
          re       = 1'b1;
          raddr    = phys(head_q, issue_q);
          rd_vld_d = 1'b1;
          rd_idx_d = issue_q;
          issue_d  = issue_q + CW'(1);
        end
        if (show_q) begin
          if (rd_vld_q) begin
            res_valid_d = 1'b1;
            status_d    = ST_OK;
            res_val_d   = rdata;
            last_d      = (rd_idx_q == count_q - CW'(1));
            if (rd_idx_q == count_q - CW'(1)) begin
              state_d = S_IDLE;
            end
          end
        end else if (rd_vld_q) begin
          if (!found_q) begin
            if (rdata == value_q) begin
              found_d = 1'b1;
              hit_d   = rdata;
            end
          end else begin
            // Entries after the match each move one place toward the head.
            we    = 1'b1;
            waddr = phys(head_q, rd_idx_q - CW'(1));
            wdata = rdata;
          end
        end else begin
          res_valid_d = 1'b1;
          last_d      = 1'b1;
          if (found_q) begin
            status_d  = ST_OK;
            res_val_d = hit_q;
            count_d   = count_q - CW'(1);
          end else begin
            status_d  = ST_NOTFOUND;
            res_val_d = '0;
          end
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      rd_vld_q    <= rd_vld_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    issue_q   <= issue_d;
    rd_idx_q  <= rd_idx_d;
    found_q   <= found_d;
    show_q    <= show_d;
    value_q   <= value_d;
    hit_q     <= hit_d;
    status_q  <= status_d;
    res_val_q <= res_val_d;
    last_q    <= last_d;
  end

  fqwr_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_entries (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign busy_o         = (state_q != S_IDLE);
  assign res_valid_o    = res_valid_q;
  assign status_o       = status_q;
  assign result_value_o = res_val_q;
  assign last_o         = last_q;

endmodule

// ===== rtl/fqwr_chk.sv =====
// Port-level checker for the FIFO queue core, bound to the top level.
module fqwr_chk (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                start_i,
  input logic                                busy_o,
  input logic                                res_valid_o,
  input logic [1:0]                          status_o,
  input logic signed [fqwr_pkg::DATA_W-1:0]  result_value_o,
  input logic                                last_o
);

  import fqwr_pkg::*;

  // The block only goes busy on a request beat.
  a_busy_from_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_o) |-> $past(start_i))
    else $error("busy rose without a request beat");

  // Leaving a multi-cycle request always shows its final result beat.
  a_end_with_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(busy_o) |-> (res_valid_o && last_o))
    else $error("request ended without a final result beat");

  // Error answers are single beats carrying zero.
  a_err_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && status_o != ST_OK) |-> (last_o && result_value_o == '0))
    else $error("error result is not a single zero beat");

  // A result that follows an idle cycle must stem from a request accepted in that cycle.
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !$past(busy_o)) |-> $past(start_i))
    else $error("result beat without a request");

endmodule

bind fifo_queue_with_remove_by_value_core fqwr_chk u_fqwr_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .res_valid_o    (res_valid_o),
  .status_o       (status_o),
  .result_value_o (result_value_o),
  .last_o         (last_o)
);
